// ----- rtl/qfu_pkg.sv -----
package qfu_pkg;

	// operation codes
	localparam logic [2:0] MODE_MUL  = 3'd0;
	localparam logic [2:0] MODE_DIV  = 3'd1;
	localparam logic [2:0] MODE_SQRT = 3'd2;
	localparam logic [2:0] MODE_SIN  = 3'd3;
	localparam logic [2:0] MODE_COS  = 3'd4;
	localparam logic [2:0] MODE_LOG2 = 3'd5;

	// q16.16 constants
	localparam logic signed [31:0] ONE_Q     = 32'sd65536;
	localparam logic signed [31:0] PI_Q      = 32'sd205887;
	localparam logic signed [31:0] HALF_PI_Q = 32'sd102943;
	localparam logic signed [31:0] TWO_PI_Q  = 32'sd411774;
	localparam logic signed [31:0] INV_FACT3 = 32'sd10923;
	localparam logic signed [31:0] INV_FACT5 = 32'sd546;
	localparam logic signed [31:0] INV_FACT7 = 32'sd13;
	localparam int NEWTON_STEPS = 8;
	localparam int SQRT_SCALE   = 8;

	// divider geometry
	localparam int DIV_W     = 48;
	localparam int DIV_SHORT = 32;
	localparam int DIV_CNT_W = 6;

	// reciprocal of a whole turn, scaled by 2^RED_SHIFT, for angle reduction
	localparam int          RED_SHIFT = 49;
	localparam logic [31:0] RED_RECIP = 32'((64'd1 << RED_SHIFT) / 64'(TWO_PI_Q));

	// multiplier operand pairs, in issue order for the sine series
	typedef enum logic [2:0] {
		MS_AB, MS_RR, MS_X2R, MS_X3C3, MS_X3X2, MS_X5C5, MS_X5X2, MS_X7C7
	} mul_sel_t;

	// divider operand sources
	typedef enum logic [1:0] {
		DS_QDIV, DS_SQRT
	} div_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     mul_go;
		mul_sel_t mul_sel;
		logic     div_go;
		div_sel_t div_sel;
		logic     red_go;
		logic     sq_step;
		logic     red_apply;
		logic     log_shift;
		logic     out_load;
	} qfu_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] mode;
		logic       a_pos;
		logic       div_done;
		logic       red_done;
		logic       sq_stop;
		logic       need_hi;
		logic       need_lo;
		logic       log_big;
	} qfu_sts_t;

endpackage

// ----- rtl/qfu_div.sv -----
module qfu_div import qfu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             short_op,
	input  logic [DIV_W-1:0] dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam logic [DIV_CNT_W-1:0] CNT_LONG  = DIV_CNT_W'(DIV_W);
	localparam logic [DIV_CNT_W-1:0] CNT_SHORT = DIV_CNT_W'(DIV_SHORT);
	localparam int PAD = DIV_W - DIV_SHORT;

	logic [DIV_W-1:0]     quo_q;
	logic [31:0]          rem_q;
	logic [31:0]          dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [32:0]          trial;
	logic [32:0]          diff;
	logic                 ge;

	// one restoring step per cycle
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	// iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= short_op ? CNT_SHORT : CNT_LONG;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers for quotient and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= short_op ? {dividend[DIV_SHORT-1:0], {PAD{1'b0}}} : dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[31:0] : trial[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/qfu_datapath.sv -----
module qfu_datapath import qfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  qfu_cmd_t           cmd,
	output qfu_sts_t           sts,
	input  logic [2:0]         mode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic signed [31:0] result
);

	localparam logic [31:0] TURN_U = TWO_PI_Q;

	logic [2:0]         mode_q;
	logic signed [31:0] a_q;
	logic signed [31:0] b_q;
	logic signed [31:0] x_q;
	logic signed [31:0] x2_q;
	logic signed [31:0] x3_q;
	logic signed [31:0] x5_q;
	logic signed [31:0] x7_q;
	logic signed [31:0] acc_q;
	logic [31:0]        g_q;
	logic [31:0]        v_q;
	logic [3:0]         k_q;
	logic signed [31:0] res_q;

	logic signed [63:0] p_s1;
	mul_sel_t           sel_s1;
	logic               mv_s1;

	logic signed [31:0] ma;
	logic signed [31:0] mb;
	logic signed [31:0] mq;

	logic [DIV_W-1:0]   dv_dividend;
	logic [31:0]        dv_divisor;
	logic               dv_short;
	logic               dv_done;
	logic [DIV_W-1:0]   dv_quo;

	logic [31:0]            red_d;
	logic [31:0]            red_d_q;
	logic [63:0]            red_p_s1;
	logic [63-RED_SHIFT:0]  red_k_s2;
	logic [31:0]            red_r_s3;
	logic [31:0]            red_rem_q;
	logic [4:0]             red_v_q;

	logic [31:0]        abs_a;
	logic [31:0]        abs_b;
	logic [32:0]        sq_sum;
	logic [31:0]        sq_next;
	logic [31:0]        div_res;
	logic [31:0]        log_res;
	logic signed [31:0] red_val;
	logic signed [31:0] final_val;
	logic               a_pos;

	assign a_pos = !a_q[31] && (a_q != '0);
	assign abs_a = a_q[31] ? -a_q : a_q;
	assign abs_b = b_q[31] ? -b_q : b_q;

	// multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MS_AB:   begin ma = a_q;  mb = b_q;       end
			MS_RR:   begin ma = x_q;  mb = x_q;       end
			MS_X2R:  begin ma = x2_q; mb = x_q;       end
			MS_X3C3: begin ma = x3_q; mb = INV_FACT3; end
			MS_X3X2: begin ma = x3_q; mb = x2_q;      end
			MS_X5C5: begin ma = x5_q; mb = INV_FACT5; end
			MS_X5X2: begin ma = x5_q; mb = x2_q;      end
			MS_X7C7: begin ma = x7_q; mb = INV_FACT7; end
			default: begin ma = a_q;  mb = b_q;       end
		endcase
	end

	// registered 32x32 product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			p_s1   <= ma * mb;
			sel_s1 <= cmd.mul_sel;
		end
	end

	// q16.16 product with arithmetic shift, wrapped
	assign mq = p_s1[47:16];

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DS_QDIV: begin
				dv_dividend = {abs_a, 16'h0000};
				dv_divisor  = abs_b;
				dv_short    = 1'b0;
			end
			DS_SQRT: begin
				dv_dividend = {16'h0000, a_q};
				dv_divisor  = g_q;
				dv_short    = 1'b1;
			end
			default: begin
				dv_dividend = {abs_a, 16'h0000};
				dv_divisor  = abs_b;
				dv_short    = 1'b0;
			end
		endcase
	end

	qfu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.short_op (dv_short),
		.dividend (dv_dividend),
		.divisor  (dv_divisor),
		.done     (dv_done),
		.quotient (dv_quo)
	);

	// newton update from the held quotient
	assign sq_sum  = {1'b0, g_q} + {1'b0, dv_quo[31:0]};
	assign sq_next = sq_sum[32:1];

	// distance past the nearer bound, in whole turns plus a remainder
	assign red_d = (x_q > PI_Q) ? (x_q - PI_Q) : (-PI_Q - x_q);

	// remainder by a whole turn: reciprocal multiply, then one correction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_v_q <= '0;
		end else begin
			red_v_q <= {red_v_q[3:0], cmd.red_go};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.red_go) begin
			red_d_q <= red_d;
		end
		if (red_v_q[0]) begin
			red_p_s1 <= red_d_q * RED_RECIP;
		end
		if (red_v_q[1]) begin
			red_k_s2 <= red_p_s1[63:RED_SHIFT];
		end
		if (red_v_q[2]) begin
			red_r_s3 <= red_d_q - {{(RED_SHIFT-32){1'b0}}, red_k_s2} * TURN_U;
		end
		if (red_v_q[3]) begin
			red_rem_q <= (red_r_s3 >= TURN_U) ? red_r_s3 - TURN_U : red_r_s3;
		end
	end

	// angle after one reduction by whole turns
	always_comb begin
		if (x_q > PI_Q) begin
			red_val = (red_rem_q == '0) ? PI_Q : PI_Q + $signed(red_rem_q) - TWO_PI_Q;
		end else begin
			red_val = (red_rem_q == '0) ? -PI_Q : -PI_Q - $signed(red_rem_q) + TWO_PI_Q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			a_q    <= operand_a;
			b_q    <= operand_b;
			x_q    <= (mode == MODE_COS) ? operand_a + HALF_PI_Q : operand_a;
			v_q    <= operand_a;
			k_q    <= '0;
			g_q    <= (operand_a[31:1] == '0) ? 32'd1 : {1'b0, operand_a[31:1]};
		end else begin
			if (cmd.red_apply) begin
				x_q <= red_val;
			end
			if (cmd.sq_step) begin
				g_q <= sq_next;
			end
			if (cmd.log_shift) begin
				v_q <= {1'b0, v_q[31:1]};
				k_q <= k_q + 1'b1;
			end
		end
		if (mv_s1) begin
			case (sel_s1)
				MS_AB:   acc_q <= mq;
				MS_RR:   x2_q  <= mq;
				MS_X2R:  x3_q  <= mq;
				MS_X3C3: acc_q <= x_q - mq;
				MS_X3X2: x5_q  <= mq;
				MS_X5C5: acc_q <= acc_q + mq;
				MS_X5X2: x7_q  <= mq;
				MS_X7C7: acc_q <= acc_q - mq;
				default: acc_q <= mq;
			endcase
		end
	end

	// final value per operation
	assign div_res = (a_q[31] ^ b_q[31]) ? -dv_quo[31:0] : dv_quo[31:0];
	assign log_res = {12'h000, k_q, 16'h0000} + v_q - ONE_Q;

	always_comb begin
		case (mode_q)
			MODE_MUL:  final_val = acc_q;
			MODE_DIV:  final_val = (b_q == '0) ? '0 : div_res;
			MODE_SQRT: final_val = a_pos ? {g_q[31-SQRT_SCALE:0], {SQRT_SCALE{1'b0}}} : '0;
			MODE_SIN:  final_val = acc_q;
			MODE_COS:  final_val = acc_q;
			MODE_LOG2: final_val = a_pos ? log_res : '0;
			default:   final_val = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= final_val;
		end
	end

	assign result = res_q;

	// status to the controller
	assign sts.mode     = mode_q;
	assign sts.a_pos    = a_pos;
	assign sts.div_done = dv_done;
	assign sts.red_done = red_v_q[4];
	assign sts.sq_stop  = sq_next >= g_q;
	assign sts.need_hi  = x_q > PI_Q;
	assign sts.need_lo  = x_q < -PI_Q;
	assign sts.log_big  = |v_q[31:17];

endmodule

// ----- rtl/qfu_ctrl.sv -----
module qfu_ctrl import qfu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  qfu_sts_t sts,
	output qfu_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_MUL_ISSUE, ST_MUL_WAIT, ST_DIV_WAIT,
		ST_SQ_DIV, ST_SQ_WAIT, ST_SQ_UPD, ST_TRIG, ST_RED_WAIT,
		ST_RED_APPLY, ST_LOG, ST_FIN
	} state_t;

	localparam logic [2:0] LAST_STEP = 3'(NEWTON_STEPS - 1);

	state_t     state_q;
	mul_sel_t   mul_idx_q;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic       in_xfer;
	logic       out_free;

	assign in_stall = state_q != ST_IDLE;
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = mul_idx_q;
		cmd.div_sel   = DS_QDIV;
		cmd.load      = in_xfer;
		case (state_q)
			ST_DISPATCH: begin
				if (sts.mode == MODE_DIV) begin
					cmd.div_go = 1'b1;
				end
			end
			ST_MUL_ISSUE: cmd.mul_go = 1'b1;
			ST_SQ_DIV: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DS_SQRT;
			end
			ST_SQ_UPD:    cmd.sq_step   = !sts.sq_stop;
			ST_TRIG:      cmd.red_go    = sts.need_hi || sts.need_lo;
			ST_RED_APPLY: cmd.red_apply = 1'b1;
			ST_LOG:       cmd.log_shift = sts.log_big;
			ST_FIN:       cmd.out_load  = out_free;
			default: ;
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_idx_q   <= MS_AB;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// set when a result is loaded, cleared on transfer
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					step_q <= '0;
					case (sts.mode)
						MODE_MUL: begin
							mul_idx_q <= MS_AB;
							state_q   <= ST_MUL_ISSUE;
						end
						MODE_DIV:  state_q <= ST_DIV_WAIT;
						MODE_SQRT: state_q <= sts.a_pos ? ST_SQ_DIV : ST_FIN;
						MODE_SIN:  state_q <= ST_TRIG;
						MODE_COS:  state_q <= ST_TRIG;
						MODE_LOG2: state_q <= sts.a_pos ? ST_LOG : ST_FIN;
						default:   state_q <= ST_FIN;
					endcase
				end
				ST_MUL_ISSUE: state_q <= ST_MUL_WAIT;
				ST_MUL_WAIT: begin
					if (mul_idx_q == MS_AB || mul_idx_q == MS_X7C7) begin
						state_q <= ST_FIN;
					end else begin
						mul_idx_q <= mul_sel_t'(mul_idx_q + 3'd1);
						state_q   <= ST_MUL_ISSUE;
					end
				end
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_SQ_DIV: state_q <= ST_SQ_WAIT;
				ST_SQ_WAIT: begin
					if (sts.div_done) begin
						state_q <= ST_SQ_UPD;
					end
				end
				ST_SQ_UPD: begin
					if (sts.sq_stop || step_q == LAST_STEP) begin
						state_q <= ST_FIN;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_SQ_DIV;
					end
				end
				ST_TRIG: begin
					if (sts.need_hi || sts.need_lo) begin
						state_q <= ST_RED_WAIT;
					end else begin
						mul_idx_q <= MS_RR;
						state_q   <= ST_MUL_ISSUE;
					end
				end
				ST_RED_WAIT: begin
					if (sts.red_done) begin
						state_q <= ST_RED_APPLY;
					end
				end
				ST_RED_APPLY: state_q <= ST_TRIG;
				ST_LOG: begin
					if (!sts.log_big) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/q16_math_function_unit.sv -----
// Signed Q16.16 function unit: mul, div, sqrt, sin, cos, log2 on one shared
// 32x32 multiplier, one shared radix-2 restoring divider and a reciprocal
// multiply that reduces angles by whole turns.
// Input channel: in_valid / in_stall with mode, operand_a, operand_b; a
// transfer happens on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with result; one result per item,
// held stable while out_stall is high.
// One item is worked at a time; in_stall is low only while the unit is idle,
// so the next transfer can come in the cycle after the previous result is loaded.
// A finished result sits in the output register, so the next item can be
// taken while that result is still waiting on a stalled receiver; the next
// result then waits until that register is free.
// Work from input transfer to out_valid: mul runs one multiply, div 48
//   divider steps, log2 one halving per step until the operand is below 2.0,
//   sqrt up to 8 Newton steps of 32 divider steps each, sin/cos the series,
//   after a reduction by whole turns when the angle needs one; non-positive
//   sqrt or log2 and unused codes go straight to the result.
// The divider, one quotient bit per cycle, paces div and sqrt; the series
// runs seven dependent multiplies.
// Reset returns the controller to idle and clears out_valid.
module q16_math_function_unit import qfu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result
);

	qfu_cmd_t cmd;
	qfu_sts_t sts;

	// sequencing
	qfu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic
	qfu_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.result    (result)
	);

endmodule
